// ----- hw/rtl/slseq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slseq_pkg;

   localparam int unsigned CFG_WIDTH     = 26;
   localparam int unsigned CFG_IDX_WIDTH = 3;
   localparam int unsigned LED_COUNT     = 5;
   localparam int unsigned LED_IDX_WIDTH = 3;

   typedef enum logic [1:0] {
      CMD_TICK         = 2'd0,
      CMD_FLASH_NORMAL = 2'd1,
      CMD_FLASH_CROSS  = 2'd2,
      CMD_UNUSED       = 2'd3
   } cmd_type;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_CROSS  = 2'd1;
   localparam logic [1:0] MODE_AP     = 2'd2;

   typedef enum logic [CFG_IDX_WIDTH-1:0] {
      CFG_ATT_ON      = 3'd0,
      CFG_ATT_OFF     = 3'd1,
      CFG_AP_ON       = 3'd2,
      CFG_AP_OFF      = 3'd3,
      CFG_CTRL_NORMAL = 3'd4,
      CFG_CTRL_CROSS  = 3'd5,
      CFG_PUMP_HOLD   = 3'd6,
      CFG_FADE_RETRY  = 3'd7
   } cfg_idx_type;

   // LED bit positions in the level vector
   localparam logic [LED_IDX_WIDTH-1:0] LED_ATT   = 3'd0;
   localparam logic [LED_IDX_WIDTH-1:0] LED_AP    = 3'd1;
   localparam logic [LED_IDX_WIDTH-1:0] LED_CTRL  = 3'd2;
   localparam logic [LED_IDX_WIDTH-1:0] LED_CROSS = 3'd3;
   localparam logic [LED_IDX_WIDTH-1:0] LED_PUMP  = 3'd4;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] attention_on_us;
      logic [CFG_WIDTH-1:0] attention_off_us;
      logic [CFG_WIDTH-1:0] ap_on_us;
      logic [CFG_WIDTH-1:0] ap_off_us;
      logic [CFG_WIDTH-1:0] control_normal_us;
      logic [CFG_WIDTH-1:0] control_cross_us;
      logic [CFG_WIDTH-1:0] pump_hold_us;
      logic [CFG_WIDTH-1:0] fade_retry_us;
   } cfg_type;

   localparam logic [CFG_WIDTH-1:0] RST_ATT_ON      = 26'd100000;
   localparam logic [CFG_WIDTH-1:0] RST_ATT_OFF     = 26'd100000;
   localparam logic [CFG_WIDTH-1:0] RST_AP_ON       = 26'd500000;
   localparam logic [CFG_WIDTH-1:0] RST_AP_OFF      = 26'd500000;
   localparam logic [CFG_WIDTH-1:0] RST_CTRL_NORMAL = 26'd150000;
   localparam logic [CFG_WIDTH-1:0] RST_CTRL_CROSS  = 26'd150000;
   localparam logic [CFG_WIDTH-1:0] RST_PUMP_HOLD   = 26'd1000000;
   localparam logic [CFG_WIDTH-1:0] RST_FADE_RETRY  = 26'd60000;

endpackage

`default_nettype wire

// ----- hw/rtl/slseq_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slseq_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [slseq_pkg::CFG_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [slseq_pkg::CFG_WIDTH-1:0]        csr_data,
   output slseq_pkg::cfg_type                          cfg
);

   slseq_pkg::cfg_type cfg_ff;
   slseq_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (slseq_pkg::cfg_idx_type'(csr_index))
            slseq_pkg::CFG_ATT_ON:      cfg_in.attention_on_us   = csr_data;
            slseq_pkg::CFG_ATT_OFF:     cfg_in.attention_off_us  = csr_data;
            slseq_pkg::CFG_AP_ON:       cfg_in.ap_on_us          = csr_data;
            slseq_pkg::CFG_AP_OFF:      cfg_in.ap_off_us         = csr_data;
            slseq_pkg::CFG_CTRL_NORMAL: cfg_in.control_normal_us = csr_data;
            slseq_pkg::CFG_CTRL_CROSS:  cfg_in.control_cross_us  = csr_data;
            slseq_pkg::CFG_PUMP_HOLD:   cfg_in.pump_hold_us      = csr_data;
            slseq_pkg::CFG_FADE_RETRY:  cfg_in.fade_retry_us     = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attention_on_us   <= slseq_pkg::RST_ATT_ON;
         cfg_ff.attention_off_us  <= slseq_pkg::RST_ATT_OFF;
         cfg_ff.ap_on_us          <= slseq_pkg::RST_AP_ON;
         cfg_ff.ap_off_us         <= slseq_pkg::RST_AP_OFF;
         cfg_ff.control_normal_us <= slseq_pkg::RST_CTRL_NORMAL;
         cfg_ff.control_cross_us  <= slseq_pkg::RST_CTRL_CROSS;
         cfg_ff.pump_hold_us      <= slseq_pkg::RST_PUMP_HOLD;
         cfg_ff.fade_retry_us     <= slseq_pkg::RST_FADE_RETRY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/status_led_sequencer.sv -----
// A tick beat taken on req_ passes through the input register and then the result
//   register before it is presented on rsp_.
// Throughput: one beat per cycle while rsp_stall is low; flash and unused commands give no rsp_ beat.
// A tick waits in the input register, with req_stall high, while rsp_stall holds a result.
// Reset: synchronous, active high; all timers, phases and LED levels go to
//   zero and the CSRs return to their default times.
`timescale 1ns / 1ps
`default_nettype none

module status_led_sequencer #(
   parameter int unsigned TIME_WIDTH = 48
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_command,
   input  wire logic [TIME_WIDTH-1:0]               req_now_us,
   input  wire logic                                req_attention,
   input  wire logic [1:0]                          req_op_mode,
   input  wire logic                                req_pump_running,
   input  wire logic                                req_pump_request,
   input  wire logic                                req_fade_done,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_attention_led,
   output logic                                     rsp_ap_led,
   output logic                                     rsp_control_led,
   output logic                                     rsp_cross_led,
   output logic                                     rsp_pump_led,
   output logic                                     rsp_fade_step,
   output logic                                     rsp_all_off,
   output logic                                     rsp_update,
   // CSR write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [slseq_pkg::CFG_IDX_WIDTH-1:0] csr_index,
   input  wire logic [slseq_pkg::CFG_WIDTH-1:0]     csr_data
);

   localparam int unsigned CW = slseq_pkg::CFG_WIDTH;
   localparam int unsigned LW = slseq_pkg::LED_COUNT;

   slseq_pkg::cfg_type cfg;

   slseq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------
   logic                    s1_valid_ff;
   slseq_pkg::cmd_type      s1_cmd_ff;
   logic [TIME_WIDTH-1:0]   s1_now_ff;
   logic                    s1_attention_ff;
   logic [1:0]              s1_mode_ff;
   logic                    s1_pump_running_ff;
   logic                    s1_pump_request_ff;
   logic                    s1_fade_done_ff;

   logic s1_tick;
   logic s1_go;      // item in the input register retires this cycle
   logic rsp_load;   // and it is a tick, so it fills the result register
   logic req_take;

   assign s1_tick   = (s1_cmd_ff == slseq_pkg::CMD_TICK);
   // Non-tick commands only touch state, so they never wait on rsp_.
   assign s1_go     = s1_valid_ff && (!s1_tick || !rsp_valid || !rsp_stall);
   assign rsp_load  = s1_go && s1_tick;
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff          <= slseq_pkg::cmd_type'(req_command);
         s1_now_ff          <= req_now_us;
         s1_attention_ff    <= req_attention;
         s1_mode_ff         <= req_op_mode;
         s1_pump_running_ff <= req_pump_running;
         s1_pump_request_ff <= req_pump_request;
         s1_fade_done_ff    <= req_fade_done;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------
   logic [TIME_WIDTH-1:0] next_blink_ff,   next_blink_in;
   logic                  att_phase_ff,    att_phase_in;
   logic                  att_was_ff,      att_was_in;
   logic                  ap_phase_ff,     ap_phase_in;
   logic                  ctrl_on_ff,      ctrl_on_in;
   logic [CW-1:0]         ctrl_pend_ff,    ctrl_pend_in;
   logic [TIME_WIDTH-1:0] ctrl_off_ff,     ctrl_off_in;   // zero = idle
   logic                  pump_on_ff,      pump_on_in;
   logic [TIME_WIDTH-1:0] pump_off_ff,     pump_off_in;   // zero = idle
   logic [LW-1:0]         led_ff,          led_in;

   logic fade_step, all_off, update;

   // Separate adders for attention, AP, control and pump times; all sums wrap at TIME_WIDTH.
   logic                  pump_active;
   logic [TIME_WIDTH-1:0] att_sum, ap_sum, ctrl_sum, pump_sum, ctrl_off_eff;
   logic [slseq_pkg::LED_IDX_WIDTH-1:0] ctrl_idx;

   assign pump_active = s1_pump_running_ff || s1_pump_request_ff;
   assign att_sum  = s1_now_ff + TIME_WIDTH'(att_phase_ff ? cfg.attention_off_us
                                                           : cfg.attention_on_us);
   assign ap_sum   = s1_now_ff + TIME_WIDTH'(ap_phase_ff ? cfg.ap_off_us : cfg.ap_on_us);
   assign ctrl_sum = s1_now_ff + TIME_WIDTH'(ctrl_pend_ff);
   assign pump_sum = s1_now_ff + TIME_WIDTH'(pump_active ? cfg.pump_hold_us
                                                          : cfg.fade_retry_us);
   // A pending flash is armed at the first tick outside attention and AP mode
   assign ctrl_off_eff = (ctrl_pend_ff != '0) ? ctrl_sum : ctrl_off_ff;
   assign ctrl_idx = (s1_mode_ff == slseq_pkg::MODE_CROSS) ? slseq_pkg::LED_CROSS
                                                           : slseq_pkg::LED_CTRL;

   always_comb begin
      next_blink_in = next_blink_ff;
      att_phase_in  = att_phase_ff;
      att_was_in    = att_was_ff;
      ap_phase_in   = ap_phase_ff;
      ctrl_on_in    = ctrl_on_ff;
      ctrl_pend_in  = ctrl_pend_ff;
      ctrl_off_in   = ctrl_off_ff;
      pump_on_in    = pump_on_ff;
      pump_off_in   = pump_off_ff;
      led_in        = led_ff;
      fade_step     = 1'b0;
      all_off       = 1'b0;
      update        = 1'b0;

      if (s1_go) begin
         unique case (s1_cmd_ff)
            slseq_pkg::CMD_FLASH_NORMAL: ctrl_pend_in = cfg.control_normal_us;
            slseq_pkg::CMD_FLASH_CROSS:  ctrl_pend_in = cfg.control_cross_us;
            slseq_pkg::CMD_UNUSED: begin
            end
            slseq_pkg::CMD_TICK: begin
               priority if (s1_attention_ff) begin
                  att_was_in = 1'b1;
                  if (s1_now_ff > next_blink_ff) begin
                     next_blink_in             = att_sum;
                     att_phase_in              = !att_phase_ff;
                     led_in[slseq_pkg::LED_ATT] = !att_phase_ff;
                     update                    = 1'b1;
                  end
               end else if (att_was_ff) begin
                  // attention just ended: blank everything once
                  led_in     = '0;
                  att_was_in = 1'b0;
                  all_off    = 1'b1;
                  update     = 1'b1;
               end else if (s1_mode_ff == slseq_pkg::MODE_AP) begin
                  if (s1_now_ff > next_blink_ff) begin
                     next_blink_in             = ap_sum;
                     ap_phase_in               = !ap_phase_ff;
                     led_in[slseq_pkg::LED_AP] = !ap_phase_ff;
                     update                    = 1'b1;
                  end
               end else begin
                  ctrl_pend_in = '0;
                  ctrl_off_in  = ctrl_off_eff;
                  if (ctrl_off_eff != '0) begin
                     if (s1_now_ff > ctrl_off_eff) begin
                        if (ctrl_on_ff) begin
                           led_in[ctrl_idx] = 1'b0;
                           ctrl_on_in       = 1'b0;
                           ctrl_off_in      = '0;
                        end
                     end else if (!ctrl_on_ff) begin
                        led_in[ctrl_idx] = 1'b1;
                        ctrl_on_in       = 1'b1;
                     end
                  end else begin
                     ctrl_on_in = 1'b0;
                  end

                  if (pump_active) begin
                     // LED is only lit on the off-to-on change; an all-off
                     // blank leaves a running pump dark
                     if (!pump_on_ff) begin
                        led_in[slseq_pkg::LED_PUMP] = 1'b1;
                        pump_on_in                  = 1'b1;
                     end
                     pump_off_in = pump_sum;
                  end else if (pump_off_ff != '0 && pump_on_ff &&
                               s1_now_ff > pump_off_ff) begin
                     fade_step = 1'b1;
                     if (s1_fade_done_ff) begin
                        led_in[slseq_pkg::LED_PUMP] = 1'b0;
                        pump_on_in                  = 1'b0;
                        pump_off_in                 = '0;
                     end else begin
                        pump_off_in = pump_sum;   // retry later
                     end
                  end
                  update = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_blink_ff <= '0;
         att_phase_ff  <= 1'b0;
         att_was_ff    <= 1'b0;
         ap_phase_ff   <= 1'b0;
         ctrl_on_ff    <= 1'b0;
         ctrl_pend_ff  <= '0;
         ctrl_off_ff   <= '0;
         pump_on_ff    <= 1'b0;
         pump_off_ff   <= '0;
         led_ff        <= '0;
      end else begin
         next_blink_ff <= next_blink_in;
         att_phase_ff  <= att_phase_in;
         att_was_ff    <= att_was_in;
         ap_phase_ff   <= ap_phase_in;
         ctrl_on_ff    <= ctrl_on_in;
         ctrl_pend_ff  <= ctrl_pend_in;
         ctrl_off_ff   <= ctrl_off_in;
         pump_on_ff    <= pump_on_in;
         pump_off_ff   <= pump_off_in;
         led_ff        <= led_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic          rsp_valid_ff;
   logic [LW-1:0] rsp_led_ff;
   logic          rsp_fade_ff, rsp_all_off_ff, rsp_update_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_led_ff     <= led_in;
         rsp_fade_ff    <= fade_step;
         rsp_all_off_ff <= all_off;
         rsp_update_ff  <= update;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_attention_led = rsp_led_ff[slseq_pkg::LED_ATT];
   assign rsp_ap_led        = rsp_led_ff[slseq_pkg::LED_AP];
   assign rsp_control_led   = rsp_led_ff[slseq_pkg::LED_CTRL];
   assign rsp_cross_led     = rsp_led_ff[slseq_pkg::LED_CROSS];
   assign rsp_pump_led      = rsp_led_ff[slseq_pkg::LED_PUMP];
   assign rsp_fade_step     = rsp_fade_ff;
   assign rsp_all_off       = rsp_all_off_ff;
   assign rsp_update        = rsp_update_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // an all-off beat carries dark LEDs and an update
   a_all_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_off |-> rsp_update && !rsp_attention_led && !rsp_ap_led &&
                                   !rsp_control_led && !rsp_cross_led && !rsp_pump_led)
      else $error("all_off beat with an LED lit or no update");

   // fade steps only come from ticks outside attention and AP mode, which always update
   a_fade_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fade_step |-> rsp_update && !rsp_all_off)
      else $error("fade step without update");

   // result register only fills from a retiring tick
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !rsp_load |=> !rsp_valid_ff)
      else $error("result beat appeared without a tick");

   // input stage never stalls behind a non-tick command
   a_cmd_no_wait: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_tick |-> !req_stall)
      else $error("flash command stalled the input");

   // a lit pump LED always belongs to a pump tracked as on
   a_pump_led: assert property (@(posedge clock) disable iff (reset)
      led_ff[slseq_pkg::LED_PUMP] |-> pump_on_ff)
      else $error("pump state and LED level disagree");

endmodule

`default_nettype wire
